// ===== sv/msg_pkg.sv =====
package msg_pkg;

  localparam int LEN_W = 7;
  localparam int DEN_W = 18;
  localparam int CW = 34;
  localparam int MB_W = 34;
  localparam int PROD_W = 66;
  localparam int DIV_STEPS = 32;
  localparam int SQRT_STEPS = 16;
  localparam int CORDIC_STEPS = 16;

  localparam logic [2:0] MODE_BOX  = 3'd0;
  localparam logic [2:0] MODE_TRI  = 3'd1;
  localparam logic [2:0] MODE_SEMI = 3'd2;
  localparam logic [2:0] MODE_TRAP = 3'd3;
  localparam logic [2:0] MODE_RISE = 3'd4;
  localparam logic [2:0] MODE_FALL = 3'd5;
  localparam logic [2:0] MODE_SINE = 3'd6;
  localparam logic [2:0] MODE_COS  = 3'd7;

  localparam logic signed [CW-1:0] Q30_ONE = 34'sd1073741824;
  localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629712;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  typedef enum logic [2:0] {
    K_ZERO  = 3'd0,
    K_CONST = 3'd1,
    K_LIN   = 3'd2,
    K_SEMI  = 3'd3,
    K_TRIG  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MS_LIN  = 2'd0,
    MS_SEMI = 2'd1,
    MS_ANG  = 2'd2,
    MS_TRIG = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     setup;
    logic     res_zero;
    logic     res_const;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     ang;
    logic     div_step;
    logic     div_fin;
    logic     cordic_unit;
    logic     cordic_step;
    logic [3:0] iter;
    logic     res_trig;
    logic     emit;
  } msg_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  none;
    logic  last;
    logic  tr_zero;
    logic  out_free;
  } msg_stat_t;

  function automatic logic [31:0] atan_q30(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'h3243F6A8;
      4'd1:    v = 32'h1DAC6705;
      4'd2:    v = 32'h0FADBAFC;
      4'd3:    v = 32'h07F56EA6;
      4'd4:    v = 32'h03FEAB76;
      4'd5:    v = 32'h01FFD55B;
      4'd6:    v = 32'h00FFFAAA;
      4'd7:    v = 32'h007FFF55;
      4'd8:    v = 32'h003FFFEA;
      4'd9:    v = 32'h001FFFFD;
      4'd10:   v = 32'h000FFFFF;
      4'd11:   v = 32'h0007FFFF;
      4'd12:   v = 32'h0003FFFF;
      4'd13:   v = 32'h0001FFFF;
      4'd14:   v = 32'h0000FFFF;
      default: v = 32'h00007FFF;
    endcase
    return v;
  endfunction

  // Applies the sign to a magnitude and clamps to the signed 32-bit range.
  function automatic logic [31:0] sat_signed(input logic neg, input logic ovf,
                                             input logic [31:0] q);
    logic [31:0] v;
    if (!neg) begin
      v = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    end else begin
      v = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
    end
    return v;
  endfunction

endpackage

// ===== sv/msg_ctrl.sv =====
module msg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msg_pkg::msg_stat_t  stat,
  output msg_pkg::msg_cmd_t   cmd
);
  import msg_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_SETUP  = 12'b0000_0000_0010,
    S_SAMPLE = 12'b0000_0000_0100,
    S_SQRT   = 12'b0000_0000_1000,
    S_MUL    = 12'b0000_0001_0000,
    S_DINIT  = 12'b0000_0010_0000,
    S_DIV    = 12'b0000_0100_0000,
    S_DFIN   = 12'b0000_1000_0000,
    S_CORDIC = 12'b0001_0000_0000,
    S_TMUL   = 12'b0010_0000_0000,
    S_TFIN   = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] iter_r, iter_nxt;
  logic       ang_r, ang_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    ang_nxt   = ang_r;
    cmd       = '0;
    cmd.ang   = ang_r;
    cmd.iter  = iter_r[3:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SAMPLE;
      end
      S_SAMPLE: begin
        iter_nxt = '0;
        if (stat.none) begin
          state_nxt = S_IDLE;
        end else begin
          case (stat.kind)
            K_CONST: begin
              cmd.res_const = 1'b1;
              state_nxt     = S_EMIT;
            end
            K_LIN: begin
              cmd.mul_en  = 1'b1;
              cmd.mul_sel = MS_LIN;
              ang_nxt     = 1'b0;
              state_nxt   = S_DINIT;
            end
            K_SEMI: begin
              cmd.sqrt_init = 1'b1;
              ang_nxt       = 1'b0;
              state_nxt     = S_SQRT;
            end
            K_TRIG: begin
              if (stat.tr_zero) begin
                // The angle sits on a quadrant boundary: no rotation needed.
                cmd.cordic_unit = 1'b1;
                state_nxt       = S_TMUL;
              end else begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ANG;
                ang_nxt     = 1'b1;
                state_nxt   = S_DINIT;
              end
            end
            default: begin
              cmd.res_zero = 1'b1;
              state_nxt    = S_EMIT;
            end
          endcase
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r + 5'd1;
        if (iter_r == 5'(SQRT_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SEMI;
        state_nxt   = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        iter_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + 5'd1;
        if (iter_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        iter_nxt    = '0;
        state_nxt   = ang_r ? S_CORDIC : S_EMIT;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        iter_nxt        = iter_r + 5'd1;
        if (iter_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TRIG;
        state_nxt   = S_TFIN;
      end
      S_TFIN: begin
        cmd.res_trig = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last ? S_IDLE : S_SAMPLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
      ang_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      ang_r   <= ang_nxt;
    end
  end

endmodule

// ===== sv/msg_datapath.sv =====
module msg_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_mode,
  input  logic [15:0]         in_warp,
  input  logic signed [15:0]  in_scale,
  input  logic [7:0]          in_base_length,
  input  logic signed [15:0]  in_height,
  input  msg_pkg::msg_cmd_t   cmd,
  output msg_pkg::msg_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_sample,
  output logic                out_last
);
  import msg_pkg::*;

  // Request registers.
  logic [2:0]         mode_r;
  logic [15:0]        warp_r;
  logic signed [15:0] scale_r;
  logic [7:0]         blen_r;
  logic signed [15:0] height_r;
  logic signed [31:0] p_r;
  logic [LEN_W-1:0]   len_r;

  // Sample sequencing.
  logic [LEN_W-1:0]   k_r;
  logic [1:0]         tq_r;
  logic [5:0]         tr_r;

  // Arithmetic units.
  logic signed [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]   rem_r, den_r;
  logic [31:0]        lo_r;
  logic               ovf_r, neg_r;
  logic [31:0]        sv_r, sres_r, sbit_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [31:0]        res_r;

  logic               out_valid_r;
  logic [31:0]        out_sample_r;
  logic               out_last_r;

  // Run length and derived counts.
  logic [23:0]        wprod;
  logic [11:0]        lraw;
  logic [LEN_W-1:0]   len_sat;
  logic               long_run;
  logic [LEN_W-1:0]   lenm1, d, n_total, j, u, s0, c1, st2, qt;
  logic               last;
  kind_t              kind;
  logic [LEN_W-1:0]   idx;
  logic [DEN_W-1:0]   den_lin;

  function automatic logic [23:0] in_warp_mul(input logic [15:0] w, input logic [7:0] b);
    return 24'(w) * 24'(b);
  endfunction

  always_comb begin
    wprod   = in_warp_mul(warp_r, blen_r);
    lraw    = wprod[23:12];
    len_sat = (lraw > 12'(MAX_LEN)) ? LEN_W'(MAX_LEN) : lraw[LEN_W-1:0];
  end

  assign long_run = (len_r > LEN_W'(2));
  assign lenm1    = len_r - LEN_W'(1);
  assign d        = len_r - LEN_W'(2);
  assign j        = k_r - LEN_W'(1);
  assign u        = d >> 1;
  assign c1       = d >> 1;
  assign qt       = d >> 2;
  assign s0       = len_r[0] ? lenm1 : d;
  assign st2      = d[0] ? LEN_W'(0) : LEN_W'(1);

  always_comb begin
    if (mode_r == MODE_COS) begin
      n_total = long_run ? len_r : LEN_W'(0);
    end else if (mode_r == MODE_SINE) begin
      n_total = long_run ? len_r : LEN_W'(1);
    end else begin
      n_total = long_run ? len_r : LEN_W'(2);
    end
  end

  assign last = (k_r == n_total - LEN_W'(1));

  always_comb begin
    kind    = K_ZERO;
    idx     = '0;
    den_lin = '0;
    if (long_run) begin
      if (mode_r == MODE_COS) begin
        kind = K_TRIG;
      end else if (mode_r == MODE_SINE) begin
        // The middle sample of an odd-length sine is exactly zero.
        if (!last && !(len_r[0] && k_r == (lenm1 >> 1))) begin
          kind = K_TRIG;
        end
      end else if (k_r != '0 && !last) begin
        case (mode_r)
          MODE_BOX: begin
            kind = K_CONST;
          end
          MODE_TRI: begin
            kind    = K_LIN;
            idx     = (j < u) ? ((j + LEN_W'(1)) << 1) : (s0 - ((j - u) << 1));
            den_lin = DEN_W'({lenm1, 4'b0});
          end
          MODE_SEMI: begin
            kind = K_SEMI;
            idx  = (j < c1) ? (d - LEN_W'(1) - (j << 1)) : (st2 + ((j - c1) << 1));
          end
          MODE_TRAP: begin
            den_lin = DEN_W'({qt + LEN_W'(1), 4'b0});
            if (j < qt) begin
              kind = K_LIN;
              idx  = j + LEN_W'(1);
            end else if (j < d - qt) begin
              kind = K_CONST;
            end else begin
              kind = K_LIN;
              idx  = d - j;
            end
          end
          MODE_RISE: begin
            kind    = K_LIN;
            idx     = j + LEN_W'(1);
            den_lin = DEN_W'({d, 4'b0});
          end
          MODE_FALL: begin
            kind    = K_LIN;
            idx     = d - j;
            den_lin = DEN_W'({d, 4'b0});
          end
          default: begin
            kind = K_ZERO;
          end
        endcase
      end
    end
  end

  // Quadrant mapping of the rotated vector.
  logic signed [CW-1:0] tc, ts, tm;
  always_comb begin
    case (tq_r)
      2'd0: begin tc = cx_r;  ts = cy_r;  end
      2'd1: begin tc = -cy_r; ts = cx_r;  end
      2'd2: begin tc = -cx_r; ts = -cy_r; end
      default: begin tc = cy_r; ts = -cx_r; end
    endcase
    tm = (mode_r == MODE_COS) ? (tc - Q30_ONE) : ts;
  end

  // Shared multiplier.
  logic signed [31:0]   mul_a;
  logic signed [MB_W-1:0] mul_b;
  always_comb begin
    case (cmd.mul_sel)
      MS_LIN:  begin mul_a = p_r;         mul_b = $signed(MB_W'(idx));    end
      MS_SEMI: begin mul_a = p_r;         mul_b = $signed(MB_W'(sres_r)); end
      MS_ANG:  begin mul_a = HALF_PI_Q30; mul_b = $signed(MB_W'(tr_r));   end
      default: begin mul_a = p_r;         mul_b = tm;                     end
    endcase
  end

  logic [PROD_W-1:0] prod_mag;
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  // Divider setup.
  logic [DEN_W-1:0]  den_sel;
  logic [PROD_W-1:0] num;
  always_comb begin
    if (cmd.ang) begin
      den_sel = DEN_W'(lenm1);
    end else if (kind == K_SEMI) begin
      den_sel = DEN_W'({d, 12'b0});
    end else begin
      den_sel = den_lin;
    end
    num = prod_mag + (cmd.ang ? PROD_W'(0) : PROD_W'(den_sel >> 1));
  end

  logic [DEN_W:0]   r2;
  logic             ge;
  assign r2 = {rem_r, lo_r[31]};
  assign ge = (r2 >= {1'b0, den_r});

  // Square root step.
  logic [31:0] s_t;
  logic [13:0] dsq, isq;
  assign s_t = sres_r + sbit_r;
  assign dsq = 14'(d) * 14'(d);
  assign isq = 14'(idx) * 14'(idx);

  // CORDIC step.
  logic signed [CW-1:0] c_dx, c_dy, c_at;
  assign c_dx = cy_r >>> cmd.iter;
  assign c_dy = cx_r >>> cmd.iter;
  assign c_at = $signed({2'b0, atan_q30(cmd.iter)});

  // Constant level and rounding of the trig product.
  logic [31:0] p_mag, a_q, a_val;
  logic [PROD_W-1:0] t_round;
  assign p_mag   = p_r[31] ? (~p_r + 32'd1) : p_r;
  assign a_q     = (p_mag + 32'd8) >> 4;
  assign a_val   = p_r[31] ? (~a_q + 32'd1) : a_q;
  assign t_round = prod_mag + (PROD_W'(1) << 34);

  // Quadrant bookkeeping for the next sample.
  logic [7:0] r4, r4a, den8;
  logic [1:0] qinc;
  always_comb begin
    den8 = {1'b0, lenm1};
    r4   = {2'b0, tr_r} + 8'd4;
    qinc = 2'd0;
    r4a  = r4;
    if (r4 >= den8) begin
      r4a  = r4 - den8;
      qinc = 2'd1;
    end
    if (r4a >= den8) begin
      r4a  = r4a - den8;
      qinc = qinc + 2'd1;
    end
  end

  assign stat.kind     = kind;
  assign stat.none     = (n_total == '0);
  assign stat.last     = last;
  assign stat.tr_zero  = (tr_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= in_mode;
      warp_r   <= in_warp;
      scale_r  <= in_scale;
      blen_r   <= in_base_length;
      height_r <= in_height;
    end
    if (cmd.setup) begin
      p_r   <= 32'(scale_r) * 32'(height_r);
      len_r <= len_sat;
      k_r   <= '0;
      tq_r  <= '0;
      tr_r  <= '0;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.sqrt_init) begin
      sv_r   <= 32'({dsq - isq, 16'b0});
      sres_r <= '0;
      sbit_r <= 32'h4000_0000;
    end
    if (cmd.sqrt_step) begin
      if (sv_r >= s_t) begin
        sv_r   <= sv_r - s_t;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.div_init) begin
      den_r <= den_sel;
      ovf_r <= (num[PROD_W-1:32] >= (PROD_W - 32)'(den_sel));
      rem_r <= num[32+DEN_W-1:32];
      lo_r  <= num[31:0];
      neg_r <= prod_r[PROD_W-1];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? DEN_W'(r2 - {1'b0, den_r}) : DEN_W'(r2);
      lo_r  <= {lo_r[30:0], ge};
    end
    if (cmd.div_fin) begin
      if (cmd.ang) begin
        cz_r <= $signed({2'b0, lo_r});
        cx_r <= CORDIC_K;
        cy_r <= '0;
      end else begin
        res_r <= sat_signed(neg_r, ovf_r, lo_r);
      end
    end
    if (cmd.cordic_unit) begin
      cx_r <= Q30_ONE;
      cy_r <= '0;
    end
    if (cmd.cordic_step) begin
      if (!cz_r[CW-1]) begin
        cx_r <= cx_r - c_dx;
        cy_r <= cy_r + c_dy;
        cz_r <= cz_r - c_at;
      end else begin
        cx_r <= cx_r + c_dx;
        cy_r <= cy_r - c_dy;
        cz_r <= cz_r + c_at;
      end
    end
    if (cmd.res_zero) begin
      res_r <= '0;
    end
    if (cmd.res_const) begin
      res_r <= a_val;
    end
    if (cmd.res_trig) begin
      res_r <= sat_signed(prod_r[PROD_W-1], 1'b0, {1'b0, t_round[PROD_W-1:35]});
    end
    if (cmd.emit) begin
      out_sample_r <= res_r;
      out_last_r   <= last;
      k_r          <= k_r + LEN_W'(1);
      tr_r         <= r4a[5:0];
      tq_r         <= tq_r + qinc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = $signed(out_sample_r);
  assign out_last   = out_last_r;

endmodule

// ===== sv/motif_shape_generator_unit.sv =====
// A request is taken only while the block is idle; setup then computes the level and run length.
// Each sample is then made directly (zero or flat level), through the
// 32-step restoring divider (ramp), by a 16-step square root and then the
// divider (semicircle), or by the divider for the angle and then 16 CORDIC steps
// (sine or cosine, off a quadrant boundary). Output stalls hold the sequencer.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and empties the output.
module motif_shape_generator_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_warp,
  input  logic signed [15:0] in_scale,
  input  logic [7:0]         in_base_length,
  input  logic signed [15:0] in_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sample,
  output logic               out_last
);
  import msg_pkg::*;

  msg_cmd_t  cmd;
  msg_stat_t stat;

  msg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msg_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_warp        (in_warp),
    .in_scale       (in_scale),
    .in_base_length (in_base_length),
    .in_height      (in_height),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample     (out_sample),
    .out_last       (out_last)
  );

  // A sample beat is only written when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("sample written over an untaken beat");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted during setup");

  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit, cmd.mul_en, cmd.div_init, cmd.div_step, cmd.cordic_step,
              cmd.sqrt_step}))
    else $error("two datapath operations issued at once");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("written sample not presented");

endmodule

// ===== dv/motif_shape_generator_unit_tb.sv =====
module motif_shape_generator_unit_tb;
  import msg_pkg::*;

  localparam int MAX_SAMPLES = 64;
  localparam int STALL_LIMIT = 12000;
  localparam int HOLD_CYCLES = 3000;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629712;
  localparam longint GAIN_K = 64'sd652032874;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_phase_t;

  typedef struct {
    logic [2:0] mode;
    logic [15:0] warp;
    logic signed [15:0] scale;
    logic [7:0] blen;
    logic signed [15:0] height;
  } shape_req_t;

  typedef struct {
    logic [31:0] sample;
    logic last;
  } sample_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_mode = '0;
  logic [15:0] in_warp = '0;
  logic signed [15:0] in_scale = '0;
  logic [7:0] in_base_length = '0;
  logic signed [15:0] in_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_sample;
  logic out_last;

  shape_req_t pending_reqs[$];
  sample_beat_t expected_samples[$];
  idle_phase_t idle_phase = IDLE_NONE;
  int errors = 0;
  int quiet_cycles = 0;
  int hold_count = 0;
  bit hold_start = 1'b0;
  bit req_taken = 1'b0;

  motif_shape_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_warp(in_warp), .in_scale(in_scale),
    .in_base_length(in_base_length), .in_height(in_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample(out_sample), .out_last(out_last)
  );

  always #2 clk = ~clk;

  function automatic longint round_div(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned res;
    int unsigned bits;
    res = 0;
    bits = 32'h4000_0000;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  // Cosine and sine of 2*pi*i/den in Q2.30, quadrant folded around a CORDIC core.
  function automatic void angle_trig(longint i, longint den, output longint c,
                                     output longint s);
    longint n4, quad, rem, x, y, z, dx, dy;
    n4 = i * 4;
    quad = n4 / den;
    rem = n4 % den;
    x = ONE_Q30;
    y = 0;
    if (rem != 0) begin
      z = rem * HALF_PI / den;
      x = GAIN_K;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_q30(k[3:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_q30(k[3:0]));
        end
      end
    end
    case (quad & 3)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic void predict_shape(shape_req_t r);
    longint p, len, lraw, a, d, q, i, c, s;
    longint vals[$];
    sample_beat_t b;
    int unsigned root;
    p = longint'(r.scale) * longint'(r.height);
    lraw = (longint'(r.warp) * longint'(r.blen)) >>> 12;
    len = (lraw > MAX_SAMPLES) ? MAX_SAMPLES : lraw;
    a = round_div(p, 16);
    if (r.mode == MODE_COS) begin
      if (len > 2)
        for (i = 0; i < len; i++) begin
          angle_trig(i, len - 1, c, s);
          vals = {vals, round_div(p * (c - ONE_Q30), 32 * ONE_Q30)};
        end
    end else if (r.mode == MODE_SINE) begin
      if (len > 2)
        for (i = 0; i < len - 1; i++) begin
          // The middle of an odd-length sine is forced to exact zero.
          if ((len & 1) && i == (len - 1) / 2) begin
            vals = {vals, 64'sd0};
          end else begin
            angle_trig(i, len - 1, c, s);
            vals = {vals, round_div(p * s, 32 * ONE_Q30)};
          end
        end
      vals = {vals, 64'sd0};
    end else begin
      vals = {vals, 64'sd0};
      if (len > 2) begin
        d = len - 2;
        q = d / 4;
        case (r.mode)
          MODE_BOX: for (i = 0; i < d; i++) vals = {vals, a};
          MODE_TRI: begin
            for (i = 2; i < len - 1; i += 2) vals = {vals, round_div(p * i, 16 * (len - 1))};
            for (i = len - ((len & 1) ? 1 : 2); i > 1; i -= 2)
              vals = {vals, round_div(p * i, 16 * (len - 1))};
          end
          MODE_SEMI: begin
            for (i = d - 1; i > 0; i -= 2) begin
              root = int_sqrt(32'((d * d - i * i) << 16));
              vals = {vals, round_div(p * longint'(root), d << 12)};
            end
            if (i < 0) i += 2;
            for (; i <= d; i += 2) begin
              root = int_sqrt(32'((d * d - i * i) << 16));
              vals = {vals, round_div(p * longint'(root), d << 12)};
            end
          end
          MODE_TRAP: begin
            for (i = 1; i <= q; i++) vals = {vals, round_div(p * i, 16 * (q + 1))};
            for (i = 0; i < d - 2 * q; i++) vals = {vals, a};
            for (i = q; i > 0; i--) vals = {vals, round_div(p * i, 16 * (q + 1))};
          end
          MODE_RISE: for (i = 1; i <= d; i++) vals = {vals, round_div(p * i, 16 * d)};
          default: for (i = d; i > 0; i--) vals = {vals, round_div(p * i, 16 * d)};
        endcase
      end
      vals = {vals, 64'sd0};
    end
    foreach (vals[k]) begin
      b.sample = clamp32(vals[k]);
      b.last = (k == vals.size() - 1);
      expected_samples = {expected_samples, b};
    end
  endfunction

  function automatic shape_req_t make_req(int mode, int warp, int scale, int blen, int height);
    shape_req_t r;
    r.mode = mode[2:0];
    r.warp = warp[15:0];
    r.scale = scale[15:0];
    r.blen = blen[7:0];
    r.height = height[15:0];
    return r;
  endfunction

  function automatic shape_req_t random_req();
    shape_req_t r;
    r = make_req($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
    // Keep most runs short so that the slow per-sample math stays cheap.
    if ($urandom_range(0, 9) < 7) begin
      r.warp = 16'($urandom_range(0, 16'h2000));
      r.blen = 8'($urandom_range(0, 24));
    end
    return r;
  endfunction

  // Input driver: acceptance is seen at the rising edge, new beats go out at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_shape(pending_reqs.pop_front());
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 &&
          !((idle_phase == IDLE_SEND && $urandom_range(0, 99) < 84) ||
            (idle_phase == IDLE_BOTH && $urandom_range(0, 99) < 16))) begin
        in_valid <= 1'b1;
        in_mode <= pending_reqs[0].mode;
        in_warp <= pending_reqs[0].warp;
        in_scale <= pending_reqs[0].scale;
        in_base_length <= pending_reqs[0].blen;
        in_height <= pending_reqs[0].height;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_start = 1'b0;
      hold_count <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (idle_phase == IDLE_RECV) begin
      out_ready <= ($urandom_range(0, 99) >= 84);
    end else if (idle_phase == IDLE_BOTH) begin
      out_ready <= ($urandom_range(0, 99) >= 16);
    end else begin
      out_ready <= rst_n;
    end
  end

  // Output monitor and stall watchdog.
  always @(posedge clk) begin
    sample_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected beat sample=%0d last=%0b", $time, out_sample, out_last);
        errors++;
      end else begin
        exp_beat = expected_samples.pop_front();
        if (out_sample !== exp_beat.sample || out_last !== exp_beat.last) begin
          $display("%0t: mismatch expected sample=%0d last=%0b actual sample=%0d last=%0b",
                   $time, $signed(exp_beat.sample), exp_beat.last, out_sample, out_last);
          errors++;
        end
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_samples.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Every shape at an empty and a short run, then some at the saturated length and on edge cases.
    for (int m = 0; m < 8; m++) begin
      pending_reqs = {pending_reqs, make_req(m, 16'h1000, 16'h1000, 0, 16'h0100)};
      pending_reqs = {pending_reqs, make_req(m, 16'h1000, 16'h7FFF, 7, 16'h7FFF)};
    end
    pending_reqs = {pending_reqs, make_req(MODE_SINE, 16'h1000, 16'h1000, 2, 16'h0100)};
    pending_reqs = {pending_reqs, make_req(MODE_COS, 16'h1000, 16'h1000, 3, -16'sd256)};
    pending_reqs = {pending_reqs,
                    make_req(MODE_SINE, 16'h1000, -16'sd32768, 9, -16'sd32768)};
    pending_reqs = {pending_reqs,
                    make_req(MODE_SEMI, 16'hFFFF, -16'sd32768, 255, -16'sd32768)};
    pending_reqs = {pending_reqs,
                    make_req(MODE_TRAP, 16'h1800, 16'h1000, 10, -16'sd32768)};
    pending_reqs = {pending_reqs,
                    make_req(MODE_BOX, 16'hFFFF, 16'h7FFF, 255, -16'sd32768)};
    pending_reqs = {pending_reqs, make_req(MODE_TRI, 16'h1000, -16'sd4096, 8, 16'h0380)};
    pending_reqs = {pending_reqs, make_req(MODE_FALL, 16'h0800, 16'h1000, 255, 16'h0100)};
    wait_drained();

    for (int ph = IDLE_NONE; ph <= IDLE_BOTH; ph++) begin
      idle_phase = idle_phase_t'(ph);
      for (int n = 0; n < 18; n++) pending_reqs = {pending_reqs, random_req()};
      wait_drained();
    end

    // Hold the output off so the block fills and backs up its input.
    idle_phase = IDLE_NONE;
    hold_start = 1'b1;
    pending_reqs = {pending_reqs, make_req(MODE_RISE, 16'h1000, 16'h1000, 12, 16'h0100)};
    for (int n = 0; n < 2; n++) pending_reqs = {pending_reqs, random_req()};
    wait_drained();

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
